// ----- sv/gji_pkg.sv -----
// Shared types and constants for the gripper joint interpolator.
// Used by the interfaces, the controller, the datapath and the top level.
package gji_pkg;

	localparam int CURVE_COUNT = 7;
	localparam int VAL_W       = 16;
	localparam int POS_W       = 8;
	localparam int CNT_W       = 5;
	localparam int K_W         = 4;
	localparam int J_W         = 4;
	localparam int EVALS       = 10;
	localparam int DIV_STEPS   = 16;
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;

	localparam logic [2:0]       CURVE_SCISSOR = 3'd6;
	localparam logic [POS_W-1:0] PINCH_MODE    = 8'd1;
	localparam logic             CMD_LOAD      = 1'b0;
	localparam logic             CMD_EVAL      = 1'b1;

	typedef enum logic [1:0] {
		RD_FIRST = 2'd0,
		RD_LAST  = 2'd1,
		RD_K     = 2'd2
	} rd_mode_t;

	typedef struct packed {
		logic           load_we;
		logic           latch;
		rd_mode_t       rd_mode;
		logic [K_W-1:0] rd_k;
		logic [K_W-1:0] k_now;
		logic [J_W-1:0] j;
		logic           cap_prev;
		logic           cap_cur;
		logic           mul;
		logic           div_init;
		logic           div_step;
		logic           wr_direct;
		logic           wr_interp;
		logic           out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic v_le_x;
		logic v_ge_x;
		logic k_last;
	} dp_sts_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] a_proximal;
		logic signed [VAL_W-1:0] a_middle;
		logic signed [VAL_W-1:0] a_distal;
		logic signed [VAL_W-1:0] b_scissor;
		logic signed [VAL_W-1:0] b_proximal;
		logic signed [VAL_W-1:0] b_middle;
		logic signed [VAL_W-1:0] b_distal;
		logic signed [VAL_W-1:0] c_scissor;
		logic signed [VAL_W-1:0] c_proximal;
		logic signed [VAL_W-1:0] c_middle;
		logic signed [VAL_W-1:0] c_distal;
	} res_t;

	// Evaluation slot 0 is the scissor curve, then three curves per finger.
	function automatic logic [2:0] curve_of(input logic [J_W-1:0] j, input logic pinch);
		logic [2:0] off;
		logic [2:0] set;
		set = pinch ? 3'd3 : 3'd0;
		case (j)
			4'd1, 4'd4, 4'd7: off = 3'd0;
			4'd2, 4'd5, 4'd8: off = 3'd1;
			default:          off = 3'd2;
		endcase
		return (j == '0) ? CURVE_SCISSOR : set + off;
	endfunction

endpackage

// ----- sv/gji_if.sv -----
// Request and result channel interfaces of the gripper joint interpolator.
// Depends on gji_pkg for field widths.
interface gji_in_if import gji_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic                    command;
	logic [2:0]              curve_select;
	logic [3:0]              point_index;
	logic [15:0]             point_x;
	logic signed [15:0]      point_y;
	logic [POS_W-1:0]        grip_mode;
	logic [POS_W-1:0]        pos_a;
	logic [POS_W-1:0]        pos_b;
	logic [POS_W-1:0]        pos_c;
	logic [POS_W-1:0]        pos_scissor;

	modport source (output valid, command, curve_select, point_index, point_x, point_y,
		grip_mode, pos_a, pos_b, pos_c, pos_scissor, input ready);
	modport sink (input valid, command, curve_select, point_index, point_x, point_y,
		grip_mode, pos_a, pos_b, pos_c, pos_scissor, output ready);
endinterface

interface gji_out_if import gji_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] a_proximal;
	logic signed [VAL_W-1:0] a_middle;
	logic signed [VAL_W-1:0] a_distal;
	logic signed [VAL_W-1:0] b_scissor;
	logic signed [VAL_W-1:0] b_proximal;
	logic signed [VAL_W-1:0] b_middle;
	logic signed [VAL_W-1:0] b_distal;
	logic signed [VAL_W-1:0] c_scissor;
	logic signed [VAL_W-1:0] c_proximal;
	logic signed [VAL_W-1:0] c_middle;
	logic signed [VAL_W-1:0] c_distal;

	modport source (output valid, a_proximal, a_middle, a_distal, b_scissor, b_proximal,
		b_middle, b_distal, c_scissor, c_proximal, c_middle, c_distal, input ready);
	modport sink (input valid, a_proximal, a_middle, a_distal, b_scissor, b_proximal,
		b_middle, b_distal, c_scissor, c_proximal, c_middle, c_distal, output ready);
endinterface

// ----- sv/gji_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gji_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 112
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/gji_ctrl.sv -----
// Sequencing state machine of the gripper joint interpolator.
// Depends on gji_pkg; drives the datapath through ctrl_cmd_t.
module gji_ctrl import gji_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      in_command,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);
	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_RD0   = 11'b000_0000_0010,
		S_CHK0  = 11'b000_0000_0100,
		S_CHKN  = 11'b000_0000_1000,
		S_SCAN  = 11'b000_0001_0000,
		S_MUL   = 11'b000_0010_0000,
		S_DINIT = 11'b000_0100_0000,
		S_DIV   = 11'b000_1000_0000,
		S_FIN   = 11'b001_0000_0000,
		S_NEXT  = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t         state_q, state_d;
	logic [J_W-1:0] j_q, j_d;
	logic [K_W-1:0] k_q, k_d;
	logic [3:0]     dcnt_q, dcnt_d;
	logic           ov_q;
	logic           acc;

	assign in_ready  = (state_q == S_IDLE);
	assign acc       = in_valid && in_ready;
	assign out_valid = ov_q;

	always_comb begin
		cmd       = '0;
		cmd.j     = j_q;
		cmd.k_now = k_q;
		state_d   = state_q;
		j_d       = j_q;
		k_d       = k_q;
		dcnt_d    = dcnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (in_command == CMD_EVAL) begin
						cmd.latch = 1'b1;
						j_d       = '0;
						state_d   = S_RD0;
					end else begin
						cmd.load_we = 1'b1;
					end
				end
			end
			S_RD0: begin
				cmd.rd_mode = RD_FIRST;
				state_d     = S_CHK0;
			end
			S_CHK0: begin
				cmd.cap_prev = 1'b1;
				if (sts.v_le_x) begin
					cmd.wr_direct = 1'b1;
					state_d       = S_NEXT;
				end else begin
					cmd.rd_mode = RD_LAST;
					state_d     = S_CHKN;
				end
			end
			S_CHKN: begin
				if (sts.v_ge_x) begin
					cmd.wr_direct = 1'b1;
					state_d       = S_NEXT;
				end else begin
					cmd.rd_mode = RD_K;
					cmd.rd_k    = K_W'(1);
					k_d         = K_W'(1);
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				// Stop at the first breakpoint above the input, or at the last one.
				if (!sts.v_ge_x || sts.k_last) begin
					cmd.cap_cur = 1'b1;
					state_d     = S_MUL;
				end else begin
					cmd.cap_prev = 1'b1;
					cmd.rd_mode  = RD_K;
					cmd.rd_k     = k_q + K_W'(1);
					k_d          = k_q + K_W'(1);
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				dcnt_d       = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				dcnt_d       = dcnt_q + 4'd1;
				if (dcnt_q == 4'(DIV_STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.wr_interp = 1'b1;
				state_d       = S_NEXT;
			end
			S_NEXT: begin
				if (j_q == J_W'(EVALS - 1)) begin
					state_d = S_DONE;
				end else begin
					j_d     = j_q + J_W'(1);
					state_d = S_RD0;
				end
			end
			S_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q     <= '0;
			k_q     <= '0;
			dcnt_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			k_q     <= k_d;
			dcnt_q  <= dcnt_d;
			if (cmd.out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!ov_q || out_ready))
		else $error("result overwritten while still waiting");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		j_q <= J_W'(EVALS - 1))
		else $error("evaluation slot out of range");
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && dcnt_q != 4'(DIV_STEPS - 1)) |=> state_q == S_DIV)
		else $error("division left early");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> !in_ready)
		else $error("request taken during evaluation");
endmodule

// ----- sv/gji_dp.sv -----
// Datapath: breakpoint stores, bracket registers, multiplier, divider, results.
// Depends on gji_pkg and gji_ram; controlled by gji_ctrl.
module gji_dp import gji_pkg::*; #(
	parameter int MAX_POINTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ctrl_cmd_t                           cmd,
	output dp_sts_t                             sts,
	input  logic [CURVE_COUNT-1:0][CNT_W-1:0]   cfg,
	input  logic [2:0]                          curve_select,
	input  logic [3:0]                          point_index,
	input  logic [VAL_W-1:0]                    point_x,
	input  logic signed [VAL_W-1:0]             point_y,
	input  logic [POS_W-1:0]                    grip_mode,
	input  logic [POS_W-1:0]                    pos_a,
	input  logic [POS_W-1:0]                    pos_b,
	input  logic [POS_W-1:0]                    pos_c,
	input  logic [POS_W-1:0]                    pos_scissor,
	output res_t                                res
);
	localparam int DEPTH    = CURVE_COUNT * MAX_POINTS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int LOADABLE = (MAX_POINTS < 16) ? MAX_POINTS : 16;

	logic [ADDR_W-1:0]        waddr, raddr;
	logic                     we;
	logic [VAL_W-1:0]         rx, ry;
	logic                     pinch_q;
	logic [POS_W-1:0]         pa_q, pb_q, pc_q, ps_q;
	logic [2:0]               curve;
	logic [CNT_W-1:0]         n;
	logic [CNT_W-1:0]         nm1;
	logic [K_W-1:0]           ridx;
	logic [POS_W-1:0]         psel_v;
	logic [VAL_W-1:0]         v;
	logic [VAL_W-1:0]         xp_q, yp_q, xc_q, yc_q;
	logic signed [33:0]       prod_s1;
	logic [VAL_W-1:0]         den_s1;
	logic [33:0]              mag;
	logic [VAL_W-1:0]         rem_q, qn_q;
	logic                     neg_q;
	logic [VAL_W:0]           trial;
	logic                     fits;
	logic [VAL_W:0]           qs;
	logic [VAL_W-1:0]         interp;
	logic [VAL_W-1:0]         res_q [EVALS];
	logic [VAL_W-1:0]         dv;
	logic signed [VAL_W:0]    dy;

	assign we    = cmd.load_we && (curve_select < 3'(CURVE_COUNT))
		&& (32'(point_index) < MAX_POINTS);
	assign waddr = ADDR_W'(curve_select) * ADDR_W'(MAX_POINTS) + ADDR_W'(point_index);

	gji_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_xram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(point_x), .raddr(raddr), .rdata(rx));
	gji_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_yram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(point_y), .raddr(raddr), .rdata(ry));

	assign curve = curve_of(cmd.j, pinch_q);

	always_comb begin
		n = cfg[curve];
		if (n < CNT_W'(2)) begin
			n = CNT_W'(2);
		end else if (n > CNT_W'(LOADABLE)) begin
			n = CNT_W'(LOADABLE);
		end
		nm1 = n - CNT_W'(1);
		case (cmd.rd_mode)
			RD_FIRST: ridx = '0;
			RD_LAST:  ridx = nm1[K_W-1:0];
			default:  ridx = cmd.rd_k;
		endcase
		case (cmd.j)
			4'd0:             psel_v = ps_q;
			4'd1, 4'd2, 4'd3: psel_v = pa_q;
			4'd4, 4'd5, 4'd6: psel_v = pb_q;
			default:          psel_v = pc_q;
		endcase
	end

	assign raddr = ADDR_W'(curve) * ADDR_W'(MAX_POINTS) + ADDR_W'(ridx);
	assign v     = {psel_v, 8'h00};

	assign sts.v_le_x = (v <= rx);
	assign sts.v_ge_x = (v >= rx);
	assign sts.k_last = (CNT_W'(cmd.k_now) == nm1);

	assign dv = v - xp_q;
	assign dy = $signed({yc_q[VAL_W-1], yc_q}) - $signed({yp_q[VAL_W-1], yp_q});

	// The remainder's top half is always below the divisor, so sixteen
	// quotient bits are enough.
	assign mag    = prod_s1[33] ? 34'(-prod_s1) : 34'(prod_s1);
	assign trial  = {rem_q, qn_q[VAL_W-1]};
	assign fits   = (trial >= {1'b0, den_s1});
	assign qs     = neg_q ? (VAL_W+1)'(-{1'b0, qn_q}) : {1'b0, qn_q};
	assign interp = yp_q + qs[VAL_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			pinch_q <= (grip_mode == PINCH_MODE);
			pa_q    <= pos_a;
			pb_q    <= pos_b;
			pc_q    <= pos_c;
			ps_q    <= pos_scissor;
		end
		if (cmd.cap_prev) begin
			xp_q <= rx;
			yp_q <= ry;
		end
		if (cmd.cap_cur) begin
			xc_q <= rx;
			yc_q <= ry;
		end
		if (cmd.mul) begin
			prod_s1 <= $signed({1'b0, dv}) * dy;
			den_s1  <= xc_q - xp_q;
		end
		if (cmd.div_init) begin
			neg_q <= prod_s1[33];
			rem_q <= mag[31:16];
			qn_q  <= mag[15:0];
		end else if (cmd.div_step) begin
			rem_q <= fits ? VAL_W'(trial - {1'b0, den_s1}) : trial[VAL_W-1:0];
			qn_q  <= {qn_q[VAL_W-2:0], fits};
		end
		if (cmd.wr_direct) begin
			res_q[cmd.j] <= ry;
		end else if (cmd.wr_interp) begin
			res_q[cmd.j] <= interp;
		end
		if (cmd.out_load) begin
			res.b_scissor  <= res_q[0];
			res.c_scissor  <= (res_q[0] == 16'h8000) ? 16'sh7FFF : -$signed(res_q[0]);
			res.a_proximal <= res_q[1];
			res.a_middle   <= res_q[2];
			res.a_distal   <= res_q[3];
			res.b_proximal <= res_q[4];
			res.b_middle   <= res_q[5];
			res.b_distal   <= res_q[6];
			res.c_proximal <= res_q[7];
			res.c_middle   <= res_q[8];
			res.c_distal   <= res_q[9];
		end
	end

	a_den_positive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |-> den_s1 != '0)
		else $error("interval of zero width");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_interp |-> rem_q < den_s1)
		else $error("division remainder not reduced");
	a_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> (xp_q <= v) && (xc_q > v || sts.k_last))
		else $error("input not bracketed by breakpoints");
endmodule

// ----- sv/gripper_joint_interpolator.sv -----
// Top level of the gripper joint interpolator: APB register file and glue.
// Depends on gji_pkg, gji_if, gji_ctrl, gji_dp and gji_ram.
//
//  Channel   Direction  Handshake            Carries
//  in_ch     sink       valid/ready          load breakpoint or evaluate request
//  out_ch    source     valid/ready          eleven joint angles
//  APB       slave      psel/penable/pready  seven breakpoint counts
//
// A load request writes one breakpoint. An evaluate request runs ten curve
// evaluations one after another on a single RAM read address and a shared
// 16-step divider: a curve that clamps takes its value straight from a
// breakpoint, an interpolated one scans the breakpoints and then divides.
// No request is taken while an evaluation runs; the finished result sits in an
// output register, so a stalled result only holds the next result back.
// After reset all counts read 2 and the breakpoint stores are undefined.
module gripper_joint_interpolator import gji_pkg::*; #(
	parameter int MAX_POINTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	gji_in_if.sink             in_ch,
	gji_out_if.source          out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);
	logic [CURVE_COUNT-1:0][CNT_W-1:0] cfg_q;
	logic [2:0]                        reg_idx;
	ctrl_cmd_t                         cmd;
	dp_sts_t                           sts;
	res_t                              res;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign prdata  = (reg_idx < 3'(CURVE_COUNT)) ? PDATA_W'(cfg_q[reg_idx]) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CURVE_COUNT; i++) begin
				cfg_q[i] <= CNT_W'(2);
			end
		end else if (psel && penable && pwrite && (reg_idx < 3'(CURVE_COUNT))) begin
			cfg_q[reg_idx] <= pwdata[CNT_W-1:0];
		end
	end

	gji_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_command(in_ch.command),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	gji_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .cfg(cfg_q),
		.curve_select(in_ch.curve_select), .point_index(in_ch.point_index),
		.point_x(in_ch.point_x), .point_y(in_ch.point_y), .grip_mode(in_ch.grip_mode),
		.pos_a(in_ch.pos_a), .pos_b(in_ch.pos_b), .pos_c(in_ch.pos_c),
		.pos_scissor(in_ch.pos_scissor), .res(res)
	);

	assign out_ch.a_proximal = res.a_proximal;
	assign out_ch.a_middle   = res.a_middle;
	assign out_ch.a_distal   = res.a_distal;
	assign out_ch.b_scissor  = res.b_scissor;
	assign out_ch.b_proximal = res.b_proximal;
	assign out_ch.b_middle   = res.b_middle;
	assign out_ch.b_distal   = res.b_distal;
	assign out_ch.c_scissor  = res.c_scissor;
	assign out_ch.c_proximal = res.c_proximal;
	assign out_ch.c_middle   = res.c_middle;
	assign out_ch.c_distal   = res.c_distal;
endmodule
